[rtl/core/wima_pkg.sv]
// ----------------------------------------------------------------------------
// wima_pkg
// Shared constants and op codes of the wide integer modular ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package wima_pkg;
	localparam int DEF_WORDS     = 32;
	localparam int DEF_WORD_BITS = 32;

	localparam logic [3:0] OP_LOADA   = 4'd0;
	localparam logic [3:0] OP_LOADB   = 4'd1;
	localparam logic [3:0] OP_LOADM   = 4'd2;
	localparam logic [3:0] OP_ADD     = 4'd3;
	localparam logic [3:0] OP_SUB     = 4'd4;
	localparam logic [3:0] OP_ADDWORD = 4'd5;
	localparam logic [3:0] OP_SUBWORD = 4'd6;
	localparam logic [3:0] OP_MODADD  = 4'd7;
	localparam logic [3:0] OP_MODSUB  = 4'd8;
	localparam logic [3:0] OP_SHL     = 4'd9;
	localparam logic [3:0] OP_SHR     = 4'd10;
	localparam logic [3:0] OP_CMP     = 4'd11;
endpackage
`default_nettype wire

[rtl/core/wima_if.sv]
// ----------------------------------------------------------------------------
// wima_if
// Command and response channels of the wide integer modular ALU.
// ----------------------------------------------------------------------------
`default_nettype none
interface wima_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op;
	logic [4:0]  word_index;
	logic [31:0] data;
	logic [4:0]  shift_amount;
	logic        keep;
	modport source(output valid, op, word_index, data, shift_amount, keep, input ready);
	modport sink(input valid, op, word_index, data, shift_amount, keep, output ready);
endinterface

interface wima_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_word;
	logic [4:0]  result_index;
	logic        last;
	logic [31:0] carry_out;
	logic        a_ge_b;
	logic        a_eq_b;
	logic        a_is_zero;
	logic        a_is_odd;
	logic [9:0]  top_bit;
	modport source(output valid, result_word, result_index, last, carry_out, a_ge_b,
		a_eq_b, a_is_zero, a_is_odd, top_bit, input ready);
	modport sink(input valid, result_word, result_index, last, carry_out, a_ge_b,
		a_eq_b, a_is_zero, a_is_odd, top_bit, output ready);
endinterface
`default_nettype wire

[rtl/core/wima_ram.sv]
// ----------------------------------------------------------------------------
// wima_ram
// Operand word store with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module wima_ram #(
	parameter int WIDTH = wima_pkg::DEF_WORD_BITS,
	parameter int DEPTH = wima_pkg::DEF_WORDS
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]              rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

[rtl/core/wima_ram2.sv]
// ----------------------------------------------------------------------------
// wima_ram2
// Operand word store with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none
module wima_ram2 #(
	parameter int WIDTH = wima_pkg::DEF_WORD_BITS,
	parameter int DEPTH = wima_pkg::DEF_WORDS
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]              rd_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd2_addr,
	output logic [WIDTH-1:0]              rd2_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data  <= mem[rd_addr];
		rd2_data <= mem[rd2_addr];
	end
endmodule
`default_nettype wire

[rtl/core/wima_word_alu.sv]
// ----------------------------------------------------------------------------
// wima_word_alu
// One word step of a multi-word add or subtract with carry or borrow.
// ----------------------------------------------------------------------------
`default_nettype none
module wima_word_alu #(
	parameter int WORD_BITS = wima_pkg::DEF_WORD_BITS
) (
	input  wire logic [WORD_BITS-1:0] x,
	input  wire logic [WORD_BITS-1:0] y,
	input  wire logic                 cin,
	input  wire logic                 subtract,
	output logic [WORD_BITS-1:0]      r,
	output logic                      cout
);
	logic [WORD_BITS:0] full;

	always_comb begin
		if (subtract) begin
			full = {1'b0, x} - {1'b0, y} - {{WORD_BITS{1'b0}}, cin};
		end else begin
			full = {1'b0, x} + {1'b0, y} + {{WORD_BITS{1'b0}}, cin};
		end
		r    = full[WORD_BITS-1:0];
		cout = full[WORD_BITS];
	end
endmodule
`default_nettype wire

[rtl/core/wide_integer_modular_alu.sv]
// ----------------------------------------------------------------------------
// wide_integer_modular_alu
// Multi-word unsigned add, subtract, modular add and subtract, shift and
// compare over operands held in word stores.
// ----------------------------------------------------------------------------
// Commands arrive on cmd; a beat moves when valid and ready are both high.
// Load commands write one word of A, B or M in the cycle they are taken and
// produce no response. Arithmetic and shift commands return WORDS beats on
// rsp, least significant word first, with carry_out on the last beat.
// Compare returns one beat of flags. The block takes one command at a time:
// cmd.ready is high only while it is idle.
// Each word goes through a store read state and an execute state; modular add
// and subtract walk the words twice through the single word adder.
// A held-off rsp stalls the word walk; the pending beat sits in the output
// register. Reset returns the controller to idle and drops any pending beat;
// the operand stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module wide_integer_modular_alu #(
	parameter int WORDS     = wima_pkg::DEF_WORDS,
	parameter int WORD_BITS = wima_pkg::DEF_WORD_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	wima_cmd_if.sink  cmd,
	wima_rsp_if.source rsp
);
	localparam int WB = WORD_BITS;
	localparam int IW = $clog2(WORDS);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_EX   = 2'd2;

	logic [1:0]    state_q;
	logic          pass2_q;
	logic [IW-1:0] addr_q;
	logic [3:0]    op_q;
	logic [WB-1:0] data_q;
	logic [5:0]    n_q;
	logic          keep_q;
	logic          c_q;
	logic          ge_q, eq_q, zero_q, odd_q, flag_q;
	logic [9:0]    top_q;
	logic [WB-1:0] prev_q;
	logic [WB-1:0] shc_q;

	logic [WB-1:0] a_rd, a_rd2, b_rd, m_rd, w_rd;
	logic          a_we, w_we;
	logic [IW-1:0] a_waddr, addr_nx;
	logic [WB-1:0] a_wdata;

	logic [5:0]    n_mod;
	logic          accept, last_w, out_free, emit, advance;
	logic          is_mod, sub_mode;
	logic [WB-1:0] x, y, alu_r, res;
	logic          alu_c, cin;
	logic [2*WB-1:0] sh_tmp;
	logic [WB-1:0] cmp_x, cmp_y;
	logic          ge_nx;
	logic [15:0]   msb_pos;
	logic [31:0]   carry_fin;

	assign accept   = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign last_w   = (addr_q == IW'(WORDS - 1));
	assign out_free = !rsp.valid || rsp.ready;
	assign is_mod   = (op_q == wima_pkg::OP_MODADD) || (op_q == wima_pkg::OP_MODSUB);
	assign addr_nx  = addr_q + IW'(1);

	always_comb begin
		n_mod = {1'b0, cmd.shift_amount};
		for (int k = 0; k < 4; k++) begin
			if (n_mod >= 6'(WB)) begin
				n_mod = n_mod - 6'(WB);
			end
		end
	end

	wima_ram2 #(.WIDTH(WB), .DEPTH(WORDS)) u_ram_a (
		.clk(clk), .wr_en(a_we), .wr_addr(a_waddr), .wr_data(a_wdata),
		.rd_addr(addr_q), .rd_data(a_rd), .rd2_addr(addr_nx), .rd2_data(a_rd2)
	);
	wima_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_ram_b (
		.clk(clk), .wr_en(accept && cmd.op == wima_pkg::OP_LOADB &&
			int'(cmd.word_index) < WORDS),
		.wr_addr(IW'(cmd.word_index)), .wr_data(WB'(cmd.data)),
		.rd_addr(addr_q), .rd_data(b_rd)
	);
	wima_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_ram_m (
		.clk(clk), .wr_en(accept && cmd.op == wima_pkg::OP_LOADM &&
			int'(cmd.word_index) < WORDS),
		.wr_addr(IW'(cmd.word_index)), .wr_data(WB'(cmd.data)),
		.rd_addr(addr_q), .rd_data(m_rd)
	);
	wima_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_ram_w (
		.clk(clk), .wr_en(w_we), .wr_addr(addr_q), .wr_data(alu_r),
		.rd_addr(addr_q), .rd_data(w_rd)
	);

	always_comb begin
		x        = pass2_q ? w_rd : a_rd;
		y        = b_rd;
		sub_mode = 1'b0;
		cin      = c_q;
		if (pass2_q) begin
			y        = m_rd;
			sub_mode = (op_q == wima_pkg::OP_MODADD);
		end else begin
			unique case (op_q)
				wima_pkg::OP_SUB, wima_pkg::OP_MODSUB: sub_mode = 1'b1;
				wima_pkg::OP_ADDWORD: y = (addr_q == '0) ? data_q : '0;
				wima_pkg::OP_SUBWORD: begin
					y        = (addr_q == '0) ? data_q : '0;
					sub_mode = 1'b1;
				end
				default: sub_mode = 1'b0;
			endcase
		end
	end

	wima_word_alu #(.WORD_BITS(WB)) u_alu (
		.x(x), .y(y), .cin(cin), .subtract(sub_mode), .r(alu_r), .cout(alu_c)
	);

	always_comb begin
		sh_tmp = '0;
		res    = alu_r;
		if (pass2_q) begin
			res = flag_q ? alu_r : w_rd;
		end else if (op_q == wima_pkg::OP_SHL) begin
			sh_tmp = {a_rd, prev_q} << n_q;
			res    = sh_tmp[2*WB-1:WB];
		end else if (op_q == wima_pkg::OP_SHR) begin
			sh_tmp = {(last_w ? {WB{1'b0}} : a_rd2), a_rd} >> n_q;
			res    = sh_tmp[WB-1:0];
		end
	end

	always_comb begin
		cmp_x = a_rd;
		cmp_y = b_rd;
		if (op_q == wima_pkg::OP_MODADD) begin
			cmp_x = alu_r;
			cmp_y = m_rd;
		end
		ge_nx = (cmp_x > cmp_y) || ((cmp_x == cmp_y) && ge_q);
		msb_pos = '0;
		for (int j = 0; j < WB; j++) begin
			if (a_rd[j]) begin
				msb_pos = 16'(j);
			end
		end
	end

	always_comb begin
		logic [2*WB-1:0] t;
		t = {{WB{1'b0}}, a_rd} << n_q;
		unique case (op_q)
			wima_pkg::OP_SHL:    carry_fin = 32'(t[2*WB-1:WB]);
			wima_pkg::OP_SHR:    carry_fin = 32'(shc_q);
			wima_pkg::OP_MODADD, wima_pkg::OP_MODSUB: carry_fin = 32'(flag_q);
			default:             carry_fin = 32'(alu_c);
		endcase
	end

	always_comb begin
		emit = 1'b0;
		if (state_q == S_EX) begin
			if (op_q == wima_pkg::OP_CMP) begin
				emit = last_w;
			end else begin
				emit = is_mod ? pass2_q : 1'b1;
			end
		end
		advance = (state_q == S_EX) && (!emit || out_free);
		w_we    = advance && !pass2_q;
		a_we    = 1'b0;
		a_waddr = addr_q;
		a_wdata = res;
		if (accept) begin
			a_we    = (cmd.op == wima_pkg::OP_LOADA) && (int'(cmd.word_index) < WORDS);
			a_waddr = IW'(cmd.word_index);
			a_wdata = WB'(cmd.data);
		end else if (advance && emit && keep_q && op_q != wima_pkg::OP_CMP) begin
			a_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass2_q <= 1'b0;
			addr_q  <= '0;
			c_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && cmd.op >= wima_pkg::OP_ADD && cmd.op <= wima_pkg::OP_CMP) begin
						state_q <= S_RD;
						pass2_q <= 1'b0;
						addr_q  <= '0;
						c_q     <= 1'b0;
					end
				end
				S_RD: state_q <= S_EX;
				S_EX: begin
					if (advance) begin
						c_q <= alu_c;
						if (!last_w) begin
							addr_q  <= addr_nx;
							state_q <= S_RD;
						end else if (is_mod && !pass2_q) begin
							addr_q  <= '0;
							pass2_q <= 1'b1;
							c_q     <= 1'b0;
							state_q <= S_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.op;
			data_q <= WB'(cmd.data);
			n_q    <= n_mod;
			keep_q <= cmd.keep;
			ge_q   <= 1'b1;
			eq_q   <= 1'b1;
			zero_q <= 1'b1;
			odd_q  <= 1'b0;
			top_q  <= '0;
			prev_q <= '0;
			shc_q  <= '0;
		end else if (advance && !pass2_q) begin
			ge_q   <= ge_nx;
			eq_q   <= eq_q && (a_rd == b_rd);
			zero_q <= zero_q && (a_rd == '0);
			prev_q <= a_rd;
			if (addr_q == '0) begin
				odd_q <= a_rd[0];
				shc_q <= WB'({a_rd, {WB{1'b0}}} >> n_q);
			end
			if (a_rd != '0) begin
				top_q <= 10'(32'(addr_q) * 32'(WB) + 32'(msb_pos));
			end
			if (last_w) begin
				if (op_q == wima_pkg::OP_MODADD) begin
					flag_q <= alu_c || ge_nx;
				end else begin
					flag_q <= alu_c;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (advance && emit) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			if (op_q == wima_pkg::OP_CMP) begin
				rsp.result_word  <= '0;
				rsp.result_index <= '0;
				rsp.last         <= 1'b1;
				rsp.carry_out    <= '0;
				rsp.a_ge_b       <= ge_nx;
				rsp.a_eq_b       <= eq_q && (a_rd == b_rd);
				rsp.a_is_zero    <= zero_q && (a_rd == '0);
				rsp.a_is_odd     <= (WORDS == 1) ? a_rd[0] : odd_q;
				rsp.top_bit      <= (a_rd != '0) ?
					10'(32'(addr_q) * 32'(WB) + 32'(msb_pos)) : top_q;
			end else begin
				rsp.result_word  <= 32'(res);
				rsp.result_index <= 5'(addr_q);
				rsp.last         <= last_w;
				rsp.carry_out    <= last_w ? carry_fin : '0;
				rsp.a_ge_b       <= 1'b0;
				rsp.a_eq_b       <= 1'b0;
				rsp.a_is_zero    <= 1'b0;
				rsp.a_is_odd     <= 1'b0;
				rsp.top_bit      <= '0;
			end
		end
	end
endmodule
`default_nettype wire
